FILE: hdl/karr_pkg.sv
// ============================================================================
// Replay ring package
// Shared widths, constants, descriptor layout and sequencer codes of the
// keyframe-aligned replay ring.
// ============================================================================
package karr_pkg;

    // Ring geometry
    localparam int RING_DEPTH = 1024;
    localparam int ADDR_W     = $clog2(RING_DEPTH);
    localparam int CNT_W      = $clog2(RING_DEPTH + 1);
    localparam int KEY_FLOOR  = 2;

    // Field widths
    localparam int SIZE_W  = 24;
    localparam int STAMP_W = 40;
    localparam int TOTAL_W = 35;
    localparam int BLIM_W  = 34;
    localparam int TLIM_W  = 40;
    localparam int CFG_W   = 40;
    localparam int OCNT_W  = 11;

    // Stream widths
    localparam int IN_DATA_W  = 64;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 112;

    // Register reset values
    localparam logic [BLIM_W-1:0] BLIM_RST = 34'd524288000;
    localparam logic [TLIM_W-1:0] TLIM_RST = 40'd15000000;

    // Register indexes
    typedef enum logic [0:0] {
        CFG_BYTE_LIMIT = 1'b0,
        CFG_TIME_LIMIT = 1'b1
    } t_cfg_idx;

    // One packet descriptor as held in the ring
    typedef struct packed {
        logic               video;
        logic               key;
        logic [SIZE_W-1:0]  size;
        logic [STAMP_W-1:0] stamp;
    } t_entry;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_EVAL,
        S_LOAD,
        S_APPEND
    } t_state;

    // Eviction phase: size limit first, then time span limit
    typedef enum logic {
        PH_BYTE,
        PH_TIME
    } t_phase;

    // Ring pointer advance with wrap
    function automatic logic [ADDR_W-1:0] next_index(input logic [ADDR_W-1:0] idx);
        logic [ADDR_W-1:0] res;
        if (idx == ADDR_W'(RING_DEPTH - 1)) begin
            res = '0;
        end else begin
            res = idx + ADDR_W'(1);
        end
        return res;
    endfunction

endpackage

FILE: hdl/keyframe_aligned_replay_ring_top.sv
// ============================================================================
// Keyframe-aligned replay ring
// Ring of media packet descriptors in one synchronous memory, with running
// byte total, front timestamp and video keyframe count. Each packet first
// evicts whole keyframe groups from the front against the size and time
// span limits, then is appended or dropped when the ring is full.
// ============================================================================
//
//  Channel   Direction  Beat contents
//  --------  ---------  ------------------------------------------------------
//  s_axis    in         tdata: payload_bytes, stamp_us; tuser: video_flag, is_keyframe
//  m_axis    out        tdata: evicted_count, dropped, occupancy, held_bytes,
//                              oldest_stamp_us, keyframes_held
//  cfg       in         write enable, register index, write data
//
//  An item passes the keyframe test and, unless that test skips eviction, the
//  limit checks (size, then time), walking each eviction group entry by
//  entry; one descriptor is read from the ring memory per cycle, which sets
//  the eviction pace.
//  Synchronous active-low reset empties the ring at once; no clearing pass.
//  A stalled result holds in the output register while the next beat is
//  accepted; the append step waits until that register frees up.
//
module keyframe_aligned_replay_ring_top
    import karr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration writes
    input  logic                  i_cfg_wen,
    input  logic                  i_cfg_idx,
    input  logic [CFG_W-1:0]      i_cfg_wdata,
    // Packet stream in
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // [23:0] payload_bytes, [63:24] stamp_us
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // [0] video_flag, [1] is_keyframe
    input  logic [IN_USER_W-1:0]  i_s_axis_tuser,
    // Result stream out
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // [10:0] evicted_count, [11] dropped, [22:12] occupancy, [57:23] held_bytes,
    // [97:58] oldest_stamp_us, [108:98] keyframes_held, [111:109] zero
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata
);

    // Sequencer and ring state
    t_state              r_state, n_state;
    t_phase              r_phase, n_phase;
    logic                r_group, n_group;
    logic [ADDR_W-1:0]   r_head, n_head;
    logic [ADDR_W-1:0]   r_tail, n_tail;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [CNT_W-1:0]    r_kf, n_kf;
    logic [CNT_W-1:0]    r_evict, n_evict;
    logic [TOTAL_W-1:0]  r_total, n_total;
    t_entry              r_front, n_front;
    t_entry              r_in;
    logic [BLIM_W-1:0]   r_blim;
    logic [TLIM_W-1:0]   r_tlim;

    // Result register
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    // Ring memory
    t_entry              r_ring [RING_DEPTH];
    t_entry              r_rdata;

    // Decisions
    t_entry              w_front;
    logic                w_accept;
    logic                w_kf_many;
    logic                w_byte_over;
    logic                w_span_over;
    logic                w_group_cont;
    logic                w_drop;
    logic                w_drop_key;
    logic                w_out_free;
    logic                w_full;
    logic                w_append;
    logic [STAMP_W-1:0]  w_span;
    logic [TOTAL_W:0]    w_need;

    assign w_accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free = !r_out_valid || i_m_axis_tready;
    assign w_full     = (r_count >= CNT_W'(RING_DEPTH));
    assign w_append   = (r_state == S_APPEND) && w_out_free && !w_full;

    // Front descriptor: fresh read data while walking a group
    assign w_front = (r_state == S_LOAD) ? r_rdata : r_front;

    assign w_kf_many   = (r_count != '0) && (r_kf > CNT_W'(KEY_FLOOR));
    assign w_need      = {1'b0, r_total} + (TOTAL_W + 1)'(r_in.size);
    assign w_byte_over = (r_count != '0) && (w_need > (TOTAL_W + 1)'(r_blim));
    assign w_span      = r_in.stamp - r_front.stamp;
    assign w_span_over = (r_count != '0) && (r_in.stamp >= r_front.stamp)
                         && (w_span > r_tlim);

    // Keep walking while the group's next entry is not a video keyframe
    assign w_group_cont = r_group && (r_count != '0) && !(r_rdata.video && r_rdata.key);

    assign w_drop = ((r_state == S_EVAL) &&
                     (((r_phase == PH_BYTE) && w_byte_over) ||
                      ((r_phase == PH_TIME) && w_span_over)))
                    || ((r_state == S_LOAD) && w_group_cont);

    assign w_drop_key = w_front.video && w_front.key;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                if (w_kf_many) begin
                    n_state = S_EVAL;
                end else begin
                    n_state = S_APPEND;
                end
            end
            S_EVAL: begin
                if (w_drop) begin
                    n_state = S_LOAD;
                end else if ((r_phase == PH_BYTE) && w_kf_many) begin
                    n_state = S_EVAL;
                end else begin
                    n_state = S_APPEND;
                end
            end
            S_LOAD: begin
                if (w_drop) begin
                    n_state = S_LOAD;
                end else begin
                    n_state = S_EVAL;
                end
            end
            S_APPEND: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Datapath updates
    always_comb begin
        n_phase = r_phase;
        n_group = r_group;
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        n_kf    = r_kf;
        n_evict = r_evict;
        n_total = r_total;
        n_front = r_front;
        case (r_state)
            S_IDLE: begin
                n_evict = '0;
                n_group = 1'b0;
            end
            S_START: begin
                // Size check only when the limit is on
                n_phase = (r_blim != '0) ? PH_BYTE : PH_TIME;
            end
            S_EVAL: begin
                if (!w_drop && (r_phase == PH_BYTE)) begin
                    n_phase = PH_TIME;
                end
                n_group = w_drop_key;
            end
            S_LOAD: begin
                n_front = r_rdata;
                if (!w_drop) begin
                    n_group = 1'b0;
                end
            end
            S_APPEND: begin
                if (w_append) begin
                    if (r_count == '0) begin
                        n_front = r_in;
                        n_head  = r_tail;
                    end
                    n_total = r_total + TOTAL_W'(r_in.size);
                    n_tail  = next_index(r_tail);
                    n_count = r_count + CNT_W'(1);
                    if (r_in.video && r_in.key) begin
                        n_kf = r_kf + CNT_W'(1);
                    end
                end
            end
            default: begin
            end
        endcase
        // Remove the front entry
        if (w_drop) begin
            if (w_drop_key && (r_kf != '0)) begin
                n_kf = r_kf - CNT_W'(1);
            end
            n_head  = next_index(r_head);
            n_count = r_count - CNT_W'(1);
            n_evict = r_evict + CNT_W'(1);
            if (r_count == CNT_W'(1)) begin
                n_total = '0;
            end else begin
                n_total = r_total - TOTAL_W'(w_front.size);
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= PH_BYTE;
            r_group <= 1'b0;
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_kf    <= '0;
            r_evict <= '0;
            r_total <= '0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_group <= n_group;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            r_kf    <= n_kf;
            r_evict <= n_evict;
            r_total <= n_total;
        end
    end

    // Front copy and latched input beat
    always_ff @(posedge i_clk) begin
        r_front <= n_front;
        if (w_accept) begin
            r_in.video <= i_s_axis_tuser[0];
            r_in.key   <= i_s_axis_tuser[1];
            r_in.size  <= i_s_axis_tdata[SIZE_W-1:0];
            r_in.stamp <= i_s_axis_tdata[SIZE_W+STAMP_W-1:SIZE_W];
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blim <= BLIM_RST;
            r_tlim <= TLIM_RST;
        end else if (i_cfg_wen) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_BYTE_LIMIT: r_blim <= i_cfg_wdata[BLIM_W-1:0];
                CFG_TIME_LIMIT: r_tlim <= i_cfg_wdata[TLIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Ring memory: write at the tail on append, read at the next head.
    // Read data is used only during eviction and writes happen only on append, so the
    // sequencer keeps the two apart.
    always_ff @(posedge i_clk) begin
        if (w_append) begin
            r_ring[r_tail] <= r_in;
        end
        r_rdata <= r_ring[n_head];
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_APPEND) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_APPEND) && w_out_free) begin
            r_out_data <= {3'b000,
                           OCNT_W'(n_kf),
                           (n_count == '0) ? {STAMP_W{1'b0}} : n_front.stamp,
                           n_total,
                           OCNT_W'(n_count),
                           w_full,
                           OCNT_W'(r_evict)};
        end
    end

    // Refuse beats while reset is held
    assign o_s_axis_tready = i_rst_n && (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

FILE: hdl/karr_checker.sv
// ============================================================================
// Replay ring port checker
// Watches the top level's ports and flags inconsistent result beats.
// ============================================================================
module karr_checker
    import karr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    input  logic                  o_s_axis_tready,
    input  logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    input  logic [OUT_DATA_W-1:0] o_m_axis_tdata
);

    // A dropped packet means the ring stayed full
    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[11]) |->
        (o_m_axis_tdata[22:12] == OCNT_W'(RING_DEPTH)))
        else $error("dropped beat without a full ring");

    // An empty ring holds no bytes and shows no front stamp
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tdata[22:12] == '0)) |->
        ((o_m_axis_tdata[57:23] == '0) && (o_m_axis_tdata[97:58] == '0)))
        else $error("empty ring reports bytes or a stamp");

    // Keyframes held never exceed the entries held
    a_kf_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[108:98] <= o_m_axis_tdata[22:12]))
        else $error("more keyframes than entries");

    // The sequencer is busy right after taking a beat
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("input taken on consecutive cycles");

    // A stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
        (o_m_axis_tvalid && $stable(o_m_axis_tdata)))
        else $error("stalled result changed");

endmodule

bind keyframe_aligned_replay_ring_top karr_checker u_karr_checker (.*);
